// File: design/tmpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmpg_pkg;

    // Display geometry
    localparam int TEXT_COLUMNS       = 22;
    localparam int TOP_BORDER_LINES   = 28;
    localparam int SIDE_BORDER_PIXELS = 32;
    localparam int DISPLAY_LINES      = 240;
    localparam int SCREEN_CELLS_DEF   = 512;

    localparam int TEXT_BOTTOM = DISPLAY_LINES - TOP_BORDER_LINES;
    localparam int TEXT_RIGHT  = SIDE_BORDER_PIXELS + 8 * TEXT_COLUMNS;

    localparam int GLYPH_DEPTH = 2048;
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
    localparam int ADDR_W      = 11;
    localparam int CELL_W      = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        FUNC_SCREEN  = 3'd0,
        FUNC_COLOUR  = 3'd1,
        FUNC_GLYPH   = 3'd2,
        FUNC_CONTROL = 3'd3,
        FUNC_PIXEL   = 3'd4
    } tmpg_func_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic [7:0]        line;
        logic [7:0]        pixel_x;
    } tmpg_in_t;

    typedef struct packed {
        logic [7:0] pixel_colour;
        logic [3:0] colour_index;
        logic       in_border;
    } tmpg_out_t;

    // Classified item passed from the front to the back through the queue
    typedef struct packed {
        tmpg_func_t        op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              border;
        logic [CELL_W-1:0] cell_idx;
        logic              cell_valid;
        logic [2:0]        row;
        logic [2:0]        bit_sel;
    } tmpg_item_t;

    typedef struct packed {
        logic clearing;
        logic queue_full;
    } tmpg_status_t;

    function automatic logic [7:0] tmpg_palette(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'h0: c = 8'h00;
            4'h1: c = 8'hFF;
            4'h2: c = 8'hE0;
            4'h3: c = 8'h1F;
            4'h4: c = 8'h61;
            4'h5: c = 8'h3C;
            4'h6: c = 8'h07;
            4'h7: c = 8'hFC;
            4'h8: c = 8'hD4;
            4'h9: c = 8'h0A;
            4'hA: c = 8'h5C;
            4'hB: c = 8'h52;
            4'hC: c = 8'h5B;
            4'hD: c = 8'hB4;
            4'hE: c = 8'h93;
            4'hF: c = 8'hA4;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/tmpg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tmpg_front
    import tmpg_pkg::*;
#(
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
) (
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire tmpg_in_t     s_data,
    input  wire tmpg_status_t status,
    output logic              push,
    output tmpg_item_t        push_item
);

    int                unsigned line_i;
    int                unsigned x_i;
    logic [7:0]        yy;
    logic [7:0]        xo;
    logic [CELL_W-1:0] cell_idx;
    logic              border;
    logic              keep;

    assign s_ready = !status.clearing && !status.queue_full;

    always_comb begin
        line_i = 32'(s_data.line);
        x_i    = 32'(s_data.pixel_x);
        border = (line_i >= 32'(DISPLAY_LINES)) || (line_i < 32'(TOP_BORDER_LINES)) ||
                 (int'(line_i) >= TEXT_BOTTOM) || (x_i < 32'(SIDE_BORDER_PIXELS)) ||
                 (x_i >= 32'(TEXT_RIGHT));
        yy   = s_data.line - 8'(TOP_BORDER_LINES);
        xo   = s_data.pixel_x - 8'(SIDE_BORDER_PIXELS);
        cell_idx = CELL_W'(yy[7:3]) * CELL_W'(TEXT_COLUMNS) + CELL_W'(xo[7:3]);

        push_item            = '0;
        push_item.addr       = s_data.address;
        push_item.data       = s_data.data;
        push_item.border     = border;
        push_item.cell_idx   = cell_idx;
        push_item.cell_valid = !border && (cell_idx < CELL_W'(SCREEN_CELLS));
        push_item.row        = yy[2:0];
        push_item.bit_sel    = xo[2:0];

        keep = 1'b1;
        unique case (s_data.func)
            FUNC_SCREEN:  push_item.op = FUNC_SCREEN;
            FUNC_COLOUR:  push_item.op = FUNC_COLOUR;
            FUNC_GLYPH:   push_item.op = FUNC_GLYPH;
            FUNC_CONTROL: push_item.op = FUNC_CONTROL;
            FUNC_PIXEL:   push_item.op = FUNC_PIXEL;
            // undefined codes: take the transfer, drop the item
            default:      keep = 1'b0;
        endcase
        push = s_valid && s_ready && keep;
    end

endmodule
`default_nettype wire

// File: design/tmpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tmpg_queue
    import tmpg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire tmpg_item_t push_item,
    input  wire logic       pop,
    output tmpg_item_t      head,
    output logic            empty,
    output logic            full
);

    tmpg_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: design/tmpg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tmpg_back
    import tmpg_pkg::*;
#(
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tmpg_item_t head,
    input  wire logic       empty,
    output logic            pop,
    output logic            clearing,
    output logic            m_valid,
    input  wire logic       m_ready,
    output tmpg_out_t       m_data
);

    localparam int SCW = $clog2(SCREEN_CELLS);

    logic [7:0]          screen_mem [SCREEN_CELLS];
    logic [3:0]          colour_mem [SCREEN_CELLS];
    logic [7:0]          glyph_mem  [GLYPH_DEPTH];

    logic [GLYPH_AW:0]   clr_cnt_reg;
    logic                adv;

    logic                s1_valid_reg;
    tmpg_item_t          s1_item_reg;
    logic [7:0]          s1_code_reg;
    logic [3:0]          s1_colour_reg;

    logic                s2_valid_reg;
    tmpg_item_t          s2_item_reg;
    logic [7:0]          s2_glyph_reg;
    logic [3:0]          s2_fg_reg;

    logic [7:0]          ctrl_reg, ctrl_next;
    logic                m_valid_reg, m_valid_next;
    tmpg_out_t           m_data_reg, m_data_next;

    logic [SCW-1:0]      scr_rd_idx;
    logic [7:0]          s1_code;
    logic [GLYPH_AW-1:0] glyph_rd_addr;
    logic                glyph_bit;
    logic [3:0]          idx;

    assign clearing = !clr_cnt_reg[GLYPH_AW];
    assign adv      = !m_valid_reg || m_ready;
    assign pop      = adv && !empty && !clearing;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign scr_rd_idx    = head.cell_valid ? head.cell_idx[SCW-1:0] : '0;
    assign s1_code       = s1_item_reg.cell_valid ? s1_code_reg : 8'h00;
    assign glyph_rd_addr = {s1_code, s1_item_reg.row};

    // Clearing pass after reset: one entry of each store per cycle until that store is cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Stage 1: screen and colour stores, written and read on pop
    always_ff @(posedge aclk) begin
        if (clearing) begin
            if (clr_cnt_reg < (GLYPH_AW+1)'(SCREEN_CELLS)) begin
                screen_mem[clr_cnt_reg[SCW-1:0]] <= 8'h00;
                colour_mem[clr_cnt_reg[SCW-1:0]] <= 4'h0;
            end
        end else if (pop) begin
            if (head.op == FUNC_SCREEN && head.addr < ADDR_W'(SCREEN_CELLS)) begin
                screen_mem[head.addr[SCW-1:0]] <= head.data;
            end
            if (head.op == FUNC_COLOUR && head.addr < ADDR_W'(SCREEN_CELLS)) begin
                colour_mem[head.addr[SCW-1:0]] <= head.data[3:0];
            end
        end
        if (pop) begin
            s1_item_reg   <= head;
            s1_code_reg   <= screen_mem[scr_rd_idx];
            s1_colour_reg <= colour_mem[scr_rd_idx];
        end
    end

    // Stage 2: glyph store
    always_ff @(posedge aclk) begin
        if (clearing) begin
            glyph_mem[clr_cnt_reg[GLYPH_AW-1:0]] <= 8'h00;
        end else if (adv && s1_valid_reg && s1_item_reg.op == FUNC_GLYPH) begin
            glyph_mem[s1_item_reg.addr[GLYPH_AW-1:0]] <= s1_item_reg.data;
        end
        if (adv) begin
            s2_item_reg  <= s1_item_reg;
            s2_glyph_reg <= glyph_mem[glyph_rd_addr];
            s2_fg_reg    <= s1_item_reg.cell_valid ? s1_colour_reg : 4'h0;
        end
    end

    // Stage 3: colour choice, palette lookup and control byte
    always_comb begin
        glyph_bit = s2_glyph_reg[3'd7 - s2_item_reg.bit_sel];
        priority if (s2_item_reg.border) begin
            idx = {1'b0, ctrl_reg[2:0]};
        end else if (ctrl_reg[3]) begin
            idx = glyph_bit ? s2_fg_reg : ctrl_reg[7:4];
        end else begin
            idx = glyph_bit ? ctrl_reg[7:4] : s2_fg_reg;
        end

        ctrl_next    = ctrl_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv) begin
            m_valid_next = s2_valid_reg && s2_item_reg.op == FUNC_PIXEL;
            if (s2_valid_reg && s2_item_reg.op == FUNC_CONTROL) begin
                ctrl_next = s2_item_reg.data;
            end
            if (s2_valid_reg && s2_item_reg.op == FUNC_PIXEL) begin
                m_data_next.pixel_colour = tmpg_palette(idx);
                m_data_next.colour_index = idx;
                m_data_next.in_border    = s2_item_reg.border;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ctrl_reg     <= 8'h00;
        end else begin
            if (adv) begin
                s1_valid_reg <= pop;
                s2_valid_reg <= s1_valid_reg;
            end
            m_valid_reg <= m_valid_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

// File: design/text_mode_pixel_generator.sv
// Character-cell text-mode pixel generator.
// Input channel (s_valid/s_ready/s_data): each transfer is either a store
// write (screen code, cell colour, glyph row, control byte) or a pixel request
// carrying a display line and a horizontal position. Undefined function codes
// are taken and dropped.
// Result channel (m_valid/m_ready/m_data): one palette byte, its palette index
// and a border flag per pixel request, in request order; writes give nothing.
// Throughput: one transfer per cycle, sustained, on both channels.
// Latency: a pixel request accepted at edge N shows on m_valid after edge N+3
// when the output is not stalled: one cycle in the queue, ending with the
// screen and colour store read, one for the glyph store read, one for the palette.
// The screen read feeds the glyph address, which sets the depth of the back
// pipeline. Writes take effect at the stage that reads the same store, so
// later requests always see earlier writes.
// Reset: a clearing pass zeroes all stores for 2048 cycles (the glyph store
// depth), during which s_ready stays low.
// Receiver stall: the result register holds, the back pipeline freezes, a
// four-entry queue keeps taking items, and s_ready drops when it is full.
`timescale 1ns / 1ps
`default_nettype none
module text_mode_pixel_generator
    import tmpg_pkg::*;
#(
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tmpg_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tmpg_out_t     m_data
);

    tmpg_status_t status;
    logic         push;
    tmpg_item_t   push_item;
    logic         pop;
    tmpg_item_t   head;
    logic         empty;
    logic         full;
    logic         clearing;

    assign status.clearing   = clearing;
    assign status.queue_full = full;

    tmpg_front #(
        .SCREEN_CELLS(SCREEN_CELLS)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .status   (status),
        .push     (push),
        .push_item(push_item)
    );

    tmpg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    tmpg_back #(
        .SCREEN_CELLS(SCREEN_CELLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .clearing(clearing),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// File: bench/tb_text_mode_pixel_generator.sv
`timescale 1ns / 1ps
module tb_text_mode_pixel_generator
    import tmpg_pkg::*;
();

    localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int RANDOM_ITEMS   = 725;

    class pixel_scoreboard;
        bit [7:0]  screen_codes [SCREEN_CELLS_DEF];
        bit [3:0]  cell_colours [SCREEN_CELLS_DEF];
        bit [7:0]  glyph_rows [GLYPH_DEPTH];
        bit [7:0]  colour_control;
        bit [7:0]  palette [16];
        tmpg_out_t expected_pixels [$];
        int        errors;

        function new();
            foreach (screen_codes[i]) screen_codes[i] = '0;
            foreach (cell_colours[i]) cell_colours[i] = '0;
            foreach (glyph_rows[i]) glyph_rows[i] = '0;
            colour_control = '0;
            errors = 0;
            palette = '{8'h00, 8'hFF, 8'hE0, 8'h1F, 8'h61, 8'h3C, 8'h07, 8'hFC,
                        8'hD4, 8'h0A, 8'h5C, 8'h52, 8'h5B, 8'hB4, 8'h93, 8'hA4};
        endfunction

        function tmpg_out_t predict_pixel(bit [7:0] y, bit [7:0] x);
            int        row_off;
            int        col_off;
            int        cell_idx;
            bit [7:0]  code;
            bit [3:0]  fg;
            bit [3:0]  bg;
            bit [3:0]  idx;
            bit [10:0] glyph_addr;
            bit        lit;
            tmpg_out_t r;
            r = '0;
            if (y >= DISPLAY_LINES || y < TOP_BORDER_LINES || y >= TEXT_BOTTOM ||
                x < SIDE_BORDER_PIXELS || x >= TEXT_RIGHT) begin
                idx = {1'b0, colour_control[2:0]};
                r.in_border = 1'b1;
            end else begin
                row_off = y - TOP_BORDER_LINES;
                col_off = x - SIDE_BORDER_PIXELS;
                cell_idx = (row_off / 8) * TEXT_COLUMNS + col_off / 8;
                code = '0;
                fg = '0;
                if (cell_idx < SCREEN_CELLS_DEF) begin
                    code = screen_codes[cell_idx];
                    fg = cell_colours[cell_idx];
                end
                glyph_addr = {code, row_off[2:0]};
                // leftmost pixel of a cell takes the glyph MSB
                lit = glyph_rows[glyph_addr][7 - col_off[2:0]];
                bg = colour_control[7:4];
                if (colour_control[3])
                    idx = lit ? fg : bg;
                else
                    idx = lit ? bg : fg;
                r.in_border = 1'b0;
            end
            r.colour_index = idx;
            r.pixel_colour = palette[idx];
            return r;
        endfunction

        function void note_request(tmpg_in_t item);
            case (item.func)
                FUNC_SCREEN: begin
                    if (item.address < SCREEN_CELLS_DEF)
                        screen_codes[item.address] = item.data;
                end
                FUNC_COLOUR: begin
                    if (item.address < SCREEN_CELLS_DEF)
                        cell_colours[item.address] = item.data[3:0];
                end
                FUNC_GLYPH:   glyph_rows[item.address] = item.data;
                FUNC_CONTROL: colour_control = item.data;
                FUNC_PIXEL:   expected_pixels.push_back(predict_pixel(item.line, item.pixel_x));
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_pixel(tmpg_out_t got);
            tmpg_out_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel result with none pending: %h", got));
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_colour !== want.pixel_colour)
                    report($sformatf("pixel_colour %h, want %h",
                                     got.pixel_colour, want.pixel_colour));
                if (got.colour_index !== want.colour_index)
                    report($sformatf("colour_index %h, want %h",
                                     got.colour_index, want.colour_index));
                if (got.in_border !== want.in_border)
                    report($sformatf("in_border %b, want %b",
                                     got.in_border, want.in_border));
            end
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tmpg_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tmpg_out_t m_data;

    pixel_scoreboard board = new();
    bit no_idle = 1'b0;
    int sink_stall = 0;
    int idle_cycles = 0;

    text_mode_pixel_generator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic tmpg_in_t make_item(logic [2:0] func, int addr, int data,
                                           int y, int x);
        tmpg_in_t item;
        item.func    = func;
        item.address = addr[ADDR_W-1:0];
        item.data    = data[7:0];
        item.line    = y[7:0];
        item.pixel_x = x[7:0];
        return item;
    endfunction

    function automatic tmpg_in_t random_item();
        tmpg_in_t item;
        int       r;
        int       code;
        item = $bits(tmpg_in_t)'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        // keep codes small so written glyph rows get displayed
        code = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        if (r < 40) begin
            item.func = FUNC_PIXEL;
            if ($urandom_range(0, 3) != 0) begin
                item.line    = 8'($urandom_range(TOP_BORDER_LINES, TEXT_BOTTOM - 1));
                item.pixel_x = 8'($urandom_range(SIDE_BORDER_PIXELS, TEXT_RIGHT - 1));
            end
        end else if (r < 55) begin
            item.func = FUNC_SCREEN;
            item.data = code[7:0];
            if ($urandom_range(0, 9) != 0)
                item.address = ADDR_W'($urandom_range(0, SCREEN_CELLS_DEF - 1));
        end else if (r < 67) begin
            item.func = FUNC_COLOUR;
            if ($urandom_range(0, 9) != 0)
                item.address = ADDR_W'($urandom_range(0, SCREEN_CELLS_DEF - 1));
        end else if (r < 87) begin
            item.func = FUNC_GLYPH;
            if ($urandom_range(0, 3) != 0)
                item.address = {code[7:0], 3'($urandom_range(0, 7))};
        end else if (r < 94) begin
            item.func = FUNC_CONTROL;
        end else begin
            item.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        end
        return item;
    endfunction

    // s_valid is only lowered before an idle gap, never between back-to-back transfers
    task automatic send_item(tmpg_in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_request(item);
    endtask

    task automatic send(logic [2:0] func, int addr, int data, int y, int x);
        send_item(make_item(func, addr, data, y, x));
    endtask

    // result side: check, pick the next stall, watch for a hang
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_pixel(m_data);
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_stall <= pick_gap();
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("text_mode_pixel_generator verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send(FUNC_PIXEL, 0, 0, 0, 0);
        send(FUNC_CONTROL, 2047, 8'hA9, 0, 0);
        send(FUNC_SCREEN, 0, 8'hFF, 0, 0);
        send(FUNC_COLOUR, 0, 8'hF7, 0, 0);
        send(FUNC_GLYPH, 2040, 8'h81, 0, 0);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS + 1);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS + 7);
        // bit 3 clear: set glyph bits show the background
        send(FUNC_CONTROL, 0, 8'h50, 0, 0);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS + 1);
        // out-of-range screen and colour writes must not land
        send(FUNC_SCREEN, 2047, 8'h12, 0, 0);
        send(FUNC_COLOUR, SCREEN_CELLS_DEF, 8'h0F, 0, 0);
        send(FUNC_SCREEN, 505, 8'h01, 0, 0);
        send(FUNC_COLOUR, 505, 8'h0C, 0, 0);
        send(FUNC_GLYPH, 15, 8'h01, 0, 0);
        send(FUNC_PIXEL, 0, 0, TEXT_BOTTOM - 1, TEXT_RIGHT - 1);
        send(FUNC_PIXEL, 0, 0, TEXT_BOTTOM, 100);
        send(FUNC_PIXEL, 0, 0, 255, 255);
        send(FUNC_PIXEL, 0, 0, 100, TEXT_RIGHT);
        send(FUNC_PIXEL, 0, 0, 100, SIDE_BORDER_PIXELS - 1);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES - 1, 100);
        send(FUNC_SPARE_LO, 0, 8'hFF, 40, 40);
        send(FUNC_SPARE_MID, 0, 8'hFF, 40, 40);
        send(FUNC_SPARE_HI, 2047, 8'hFF, 255, 255);
        send(FUNC_CONTROL, 0, 8'hFF, 0, 0);
        send(FUNC_PIXEL, 0, 0, 0, 0);
        send(FUNC_PIXEL, 0, 0, TOP_BORDER_LINES, SIDE_BORDER_PIXELS);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // run a stretch at full rate now and then
            if (i % 150 == 100)
                no_idle = 1'b1;
            else if (i % 150 == 0)
                no_idle = 1'b0;
            send_item(random_item());
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (board.errors == 0)
            $display("text_mode_pixel_generator verification clean");
        else
            $display("text_mode_pixel_generator verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/tmpg_pkg.sv
design/tmpg_front.sv
design/tmpg_queue.sv
design/tmpg_back.sv
design/text_mode_pixel_generator.sv
bench/tb_text_mode_pixel_generator.sv
